[hw/rtl/pcc_pkg.sv]
// Shared types, turn codes and helper functions for the polygon convexity check.
`default_nettype none

package pcc_pkg;

    // Coordinate and arithmetic widths fixed by the item format
    localparam int unsigned CoordW = 16;
    localparam int unsigned DiffW  = CoordW + 1;
    localparam int unsigned ProdW  = 2 * DiffW;
    localparam int unsigned CrossW = ProdW + 1;
    localparam int unsigned EpsW   = 34;

    // Number of turn checks carried per item: the running one and two closing ones
    localparam int unsigned NumChecks = 3;

    // Sign of one significant turn, or none when the turn counts as collinear
    typedef enum logic [1:0] {
        TURN_NONE = 2'd0,
        TURN_POS  = 2'd1,
        TURN_NEG  = 2'd2
    } t_turn;

    // Running record of the reference turn and any mismatch seen
    typedef struct packed {
        t_turn turn;
        logic  broken;
    } t_track;

    // Edge differences of one vertex triple (a, b, c)
    typedef struct packed {
        logic [DiffW-1:0] dx_ba;
        logic [DiffW-1:0] dy_ca;
        logic [DiffW-1:0] dy_ba;
        logic [DiffW-1:0] dx_ca;
    } t_diff;

    // Control flags that travel with an item down the pipeline
    typedef struct packed {
        logic chk_run;
        logic chk_close;
        logic last;
        logic too_few;
    } t_flags;

    // Exact difference of two signed coordinates
    function automatic logic [DiffW-1:0] coord_diff(
        input logic [CoordW-1:0] a,
        input logic [CoordW-1:0] b
    );
        return {a[CoordW-1], a} - {b[CoordW-1], b};
    endfunction

    // Folds one turn sign into the running record
    function automatic t_track fold_turn(input t_track st, input t_turn s);
        t_track res;
        res = st;
        if (s != TURN_NONE) begin
            if (st.turn == TURN_NONE) begin
                res.turn = s;
            end else if (st.turn != s) begin
                res.broken = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pcc_front.sv]
// Vertex history and the edge differences of every triple that an item closes.
`default_nettype none

module pcc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [pcc_pkg::CoordW-1:0]    i_x,
    input  wire logic [pcc_pkg::CoordW-1:0]    i_y,
    input  wire logic                          i_last,
    output pcc_pkg::t_diff                     o_diff [pcc_pkg::NumChecks],
    output pcc_pkg::t_flags                    o_flags
);
    import pcc_pkg::*;

    logic [1:0]        r_seen;
    logic [1:0]        n_seen;
    logic [CoordW-1:0] r_first_x, r_first_y, r_second_x, r_second_y;
    logic [CoordW-1:0] r_older_x, r_older_y, r_newer_x, r_newer_y;
    t_diff             r_diff [NumChecks];
    t_diff             n_diff [NumChecks];
    t_flags            r_flags;
    t_flags            n_flags;

    // Differences for (older, newer, new), (newer, new, first) and (new, first, second)
    always_comb begin
        n_diff[0].dx_ba = coord_diff(r_newer_x, r_older_x);
        n_diff[0].dy_ca = coord_diff(i_y, r_older_y);
        n_diff[0].dy_ba = coord_diff(r_newer_y, r_older_y);
        n_diff[0].dx_ca = coord_diff(i_x, r_older_x);

        n_diff[1].dx_ba = coord_diff(i_x, r_newer_x);
        n_diff[1].dy_ca = coord_diff(r_first_y, r_newer_y);
        n_diff[1].dy_ba = coord_diff(i_y, r_newer_y);
        n_diff[1].dx_ca = coord_diff(r_first_x, r_newer_x);

        n_diff[2].dx_ba = coord_diff(r_first_x, i_x);
        n_diff[2].dy_ca = coord_diff(r_second_y, i_y);
        n_diff[2].dy_ba = coord_diff(r_first_y, i_y);
        n_diff[2].dx_ca = coord_diff(r_second_x, i_x);
    end

    // Which checks apply; a polygon needs two earlier vertices before any turn exists
    always_comb begin
        n_flags.chk_run   = (r_seen >= 2'd2);
        n_flags.chk_close = i_last && (r_seen >= 2'd2);
        n_flags.last      = i_last;
        n_flags.too_few   = i_last && (r_seen < 2'd2);
    end

    // Vertex count saturates at three and starts again after the last vertex
    always_comb begin
        if (i_last) begin
            n_seen = 2'd0;
        end else if (r_seen != 2'd3) begin
            n_seen = r_seen + 2'd1;
        end else begin
            n_seen = r_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
        end else if (i_load) begin
            r_seen <= n_seen;
        end
    end

    // Coordinate history and the registered triple data
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (r_seen == 2'd0) begin
                r_first_x <= i_x;
                r_first_y <= i_y;
            end
            if (r_seen == 2'd1) begin
                r_second_x <= i_x;
                r_second_y <= i_y;
            end
            r_older_x <= r_newer_x;
            r_older_y <= r_newer_y;
            r_newer_x <= i_x;
            r_newer_y <= i_y;
            r_diff    <= n_diff;
            r_flags   <= n_flags;
        end
    end

    assign o_diff  = r_diff;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

[hw/rtl/pcc_cross.sv]
// One cross product unit: product stage, then magnitude test against epsilon.
`default_nettype none

module pcc_cross (
    input  wire logic                      i_clk,
    input  wire logic                      i_en_mul,
    input  wire logic                      i_en_cmp,
    input  wire pcc_pkg::t_diff            i_diff,
    input  wire logic [pcc_pkg::EpsW-1:0]  i_eps,
    output pcc_pkg::t_turn                 o_sign
);
    import pcc_pkg::*;

    logic signed [ProdW-1:0]  r_pa;
    logic signed [ProdW-1:0]  r_pb;
    logic signed [CrossW-1:0] cross_val;
    logic        [CrossW-1:0] mag;
    t_turn                    r_sign;
    t_turn                    n_sign;

    // The two products of the cross term
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_pa <= $signed(i_diff.dx_ba) * $signed(i_diff.dy_ca);
            r_pb <= $signed(i_diff.dy_ba) * $signed(i_diff.dx_ca);
        end
    end

    // Difference, magnitude and sign; the magnitude always fits in the epsilon width
    always_comb begin
        cross_val = {r_pa[ProdW-1], r_pa} - {r_pb[ProdW-1], r_pb};
        mag       = cross_val[CrossW-1] ? (~cross_val + 1'b1) : cross_val;
        if (mag[EpsW-1:0] <= i_eps) begin
            n_sign = TURN_NONE;
        end else if (cross_val[CrossW-1]) begin
            n_sign = TURN_NEG;
        end else begin
            n_sign = TURN_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_cmp) begin
            r_sign <= n_sign;
        end
    end

    assign o_sign = r_sign;

endmodule

`default_nettype wire

[hw/rtl/pcc_fold.sv]
// Turn sign tracking per polygon and the result register.
`default_nettype none

module pcc_fold (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire pcc_pkg::t_flags   i_flags,
    input  wire pcc_pkg::t_turn    i_sign [pcc_pkg::NumChecks],
    output logic                   o_is_convex,
    output logic                   o_too_few
);
    import pcc_pkg::*;

    t_track r_track;
    t_track n_track;
    t_track folded;
    logic   r_is_convex;
    logic   r_too_few;

    // Fold the running turn first, then the two closing turns in order
    always_comb begin
        folded = r_track;
        if (i_flags.chk_run) begin
            folded = fold_turn(folded, i_sign[0]);
        end
        if (i_flags.chk_close) begin
            folded = fold_turn(folded, i_sign[1]);
            folded = fold_turn(folded, i_sign[2]);
        end
        if (i_flags.last) begin
            n_track = '{turn: TURN_NONE, broken: 1'b0};
        end else begin
            n_track = folded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= '{turn: TURN_NONE, broken: 1'b0};
        end else if (i_adv) begin
            r_track <= n_track;
        end
    end

    // Result of a closing vertex
    always_ff @(posedge i_clk) begin
        if (i_adv && i_flags.last) begin
            r_is_convex <= !i_flags.too_few && !folded.broken;
            r_too_few   <= i_flags.too_few;
        end
    end

    assign o_is_convex = r_is_convex;
    assign o_too_few   = r_too_few;

endmodule

`default_nettype wire

[hw/rtl/polygon_convexity_check.sv]
// Throughput: one vertex per cycle when not stalled. A closing vertex gives its result
// after passing the stages below: the history register, the product stage of the three
// cross product units, the sign compare and the result register each form one stage.
// Stages advance independently, so vertices keep flowing while a result waits.
// Reset clears the vertex count, turn record, valid bits and epsilon (to zero).
`default_nettype none

module polygon_convexity_check (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [pcc_pkg::CoordW-1:0] i_vertex_x,
    input  wire logic [pcc_pkg::CoordW-1:0] i_vertex_y,
    input  wire logic                      i_last_vertex,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_is_convex,
    output logic                           o_too_few_vertices,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [pcc_pkg::EpsW-1:0]  i_cfg_data
);
    import pcc_pkg::*;

    logic          r_v1, r_v2, r_v3, r_vo;
    logic          adv1, adv2, adv3;
    logic          take1, take2, take3;
    logic          out_free;
    logic          accept;
    logic [EpsW-1:0] r_eps;
    t_flags        flags1;
    t_flags        r_flags2;
    t_flags        r_flags3;
    t_diff         diff1 [NumChecks];
    t_turn         sign3 [NumChecks];

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= '0;
        end else if (i_cfg_valid) begin
            r_eps <= i_cfg_data;
        end
    end

    // Stage flow: an item moves on when the next stage is empty or moving too;
    // only closing vertices need the result register
    always_comb begin
        out_free = !r_vo || !i_stall;
        adv3     = r_v3 && (!r_flags3.last || out_free);
        take3    = !r_v3 || adv3;
        adv2     = r_v2 && take3;
        take2    = !r_v2 || adv2;
        adv1     = r_v1 && take2;
        take1    = !r_v1 || adv1;
        o_stall  = !take1;
        accept   = i_valid && take1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (take1) begin
                r_v1 <= i_valid;
            end
            if (take2) begin
                r_v2 <= r_v1;
            end
            if (take3) begin
                r_v3 <= r_v2;
            end
            if (out_free) begin
                r_vo <= adv3 && r_flags3.last;
            end
        end
    end

    // Flags follow their item through the product and compare stages
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_flags2 <= flags1;
        end
        if (adv2) begin
            r_flags3 <= r_flags2;
        end
    end

    pcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_x     (i_vertex_x),
        .i_y     (i_vertex_y),
        .i_last  (i_last_vertex),
        .o_diff  (diff1),
        .o_flags (flags1)
    );

    for (genvar g = 0; g < NumChecks; g++) begin : g_cross
        pcc_cross u_cross (
            .i_clk    (i_clk),
            .i_en_mul (adv1),
            .i_en_cmp (adv2),
            .i_diff   (diff1[g]),
            .i_eps    (r_eps),
            .o_sign   (sign3[g])
        );
    end

    pcc_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv3),
        .i_flags     (r_flags3),
        .i_sign      (sign3),
        .o_is_convex (o_is_convex),
        .o_too_few   (o_too_few_vertices)
    );

    assign o_valid = r_vo;

    // A short polygon is never reported convex
    a_too_few_not_convex : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_few_vertices |-> !o_is_convex)
        else $error("too few vertices reported as convex");

    // The input side stalls only when the first stage holds an item that cannot move
    a_stall_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v1 && !adv1)
        else $error("input stalled with first stage free");

    // An accepted item always lands in the first stage
    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v1)
        else $error("accepted item lost at the first stage");

    // Closing checks only accompany a last vertex that is not short
    a_close_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_flags3.chk_close |-> r_flags3.last && !r_flags3.too_few)
        else $error("closing checks on a vertex that does not close a polygon");

endmodule

`default_nettype wire
